>>> rtl/ptrt_pkg.sv
// ----------------------------------------------------------------------------
// ptrt_pkg
// Shared widths, codes and types for the pending tile request tracker.
// ----------------------------------------------------------------------------
package ptrt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    localparam int KIND_W     = 3;
    localparam int EV_W       = 3;
    localparam int X_W        = 24;
    localparam int Y_W        = 24;
    localparam int Z_W        = 5;
    localparam int SRC_W      = 8;
    localparam int LAY_W      = 8;
    localparam int KEY_W      = X_W + Y_W + Z_W;
    localparam int STAMP_W    = 32;
    localparam int TMO_W      = 16;
    localparam int ENTRY_W    = KEY_W + STAMP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 56;

    localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOADED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PURGE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd5;

    localparam logic [EV_W-1:0] EV_ISSUED   = 3'd0;
    localparam logic [EV_W-1:0] EV_LOADED   = 3'd1;
    localparam logic [EV_W-1:0] EV_EMPTY    = 3'd2;
    localparam logic [EV_W-1:0] EV_COMPLETE = 3'd3;
    localparam logic [EV_W-1:0] EV_QUERY    = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_LAYER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

    typedef struct packed {
        logic [EV_W-1:0] event_res;
        logic [X_W-1:0]  out_x;
        logic [Y_W-1:0]  out_y;
        logic [Z_W-1:0]  out_zoom;
        logic            is_pending;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

>>> rtl/ptrt_out_queue.sv
// ----------------------------------------------------------------------------
// ptrt_out_queue
// Two-entry result buffer driving the master-side stream.
// ----------------------------------------------------------------------------
module ptrt_out_queue import ptrt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_push                i_push,
    output logic [1:0]           o_free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_x, out_y, out_zoom, is_pending, pad
    output logic [EV_W-1:0]      m_axis_tuser,  // event_res
    output logic                 m_axis_tlast
);

    logic    r_out_v, r_nxt_v;
    logic    n_out_v, n_nxt_v;
    t_result r_out, r_nxt;
    t_result n_out, n_nxt;
    logic    pop;

    assign pop    = r_out_v & m_axis_tready;
    assign o_free = {1'b0, ~r_out_v} + {1'b0, ~r_nxt_v};

    always_comb begin
        n_out_v = r_out_v;
        n_nxt_v = r_nxt_v;
        n_out   = r_out;
        n_nxt   = r_nxt;
        if (pop) begin
            n_out_v = r_nxt_v;
            n_out   = r_nxt;
            n_nxt_v = 1'b0;
        end
        if (i_push.count != 2'd0) begin
            if (!n_out_v) begin
                n_out_v = 1'b1;
                n_out   = i_push.r0;
            end else begin
                n_nxt_v = 1'b1;
                n_nxt   = i_push.r0;
            end
        end
        if (i_push.count == 2'd2) begin
            if (!n_out_v) begin
                n_out_v = 1'b1;
                n_out   = i_push.r1;
            end else begin
                n_nxt_v = 1'b1;
                n_nxt   = i_push.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_nxt_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            r_nxt_v <= n_nxt_v;
        end
        r_out <= n_out;
        r_nxt <= n_nxt;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {2'b00, r_out.is_pending, r_out.out_zoom, r_out.out_y, r_out.out_x};
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tlast  = r_out.last;

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nxt_v |-> r_out_v)
        else $error("second buffer entry valid without head entry");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count <= o_free)
        else $error("result push exceeds free buffer space");

endmodule

>>> rtl/pending_tile_request_tracker.sv
// ----------------------------------------------------------------------------
// pending_tile_request_tracker
// Outstanding tile request table with timestamps, reply matching and purge.
//
//   Channel   Dir  Handshake              Content
//   s_axis    in   tvalid/tready          tuser kind, tdata x/y/zoom/src/layer
//   m_axis    out  tvalid/tready          tuser event, tdata x/y/zoom/pending
//   cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Ticks pass through the exec step only, requests through exec and done. Reply,
// purge and query scan a non-empty table, one table slot read per cycle
// through the single memory read port.
// Entries stay packed in age order; a fill count marks the valid slots, so
// reset needs no clearing pass. Results go to a two-entry output buffer;
// the block holds in its final step until the buffer has room.
// ----------------------------------------------------------------------------
module pending_tile_request_tracker import ptrt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // tile_x, tile_y, zoom, reply_source,
                                                 // reply_layer, pad
    input  logic [KIND_W-1:0]     s_axis_tuser,  // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // out_x, out_y, out_zoom, is_pending, pad
    output logic [EV_W-1:0]       m_axis_tuser,  // event_res
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    logic [ENTRY_W-1:0] r_slot_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    t_state             r_state, n_state;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [KEY_W-1:0]   r_key, n_key;
    logic               r_id_ok, n_id_ok;
    logic [SRC_W-1:0]   r_own_source, n_own_source;
    logic [LAY_W-1:0]   r_own_layer, n_own_layer;
    logic [TMO_W-1:0]   r_timeout, n_timeout;
    logic [STAMP_W-1:0] r_now, n_now;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_rd, n_rd;
    logic [CW-1:0]      r_wr, n_wr;
    logic               r_pv, n_pv;
    logic               r_hit, n_hit;

    logic               accept;
    logic               mem_re, mem_we;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [KEY_W-1:0]   q_key;
    logic [STAMP_W-1:0] q_stamp, q_age;
    logic               q_match, q_aged, is_reply, drop, scan_end;
    t_result            base_res, done_res;
    logic [1:0]         res_count, q_free;
    t_push              push;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign q_key    = r_rdata[ENTRY_W-1:STAMP_W];
    assign q_stamp  = r_rdata[STAMP_W-1:0];
    assign q_age    = r_now - q_stamp;
    assign q_match  = (q_key == r_key);
    assign q_aged   = (q_age > {{(STAMP_W-TMO_W){1'b0}}, r_timeout});
    assign is_reply = (r_kind == KIND_LOADED) || (r_kind == KIND_EMPTY);
    assign drop     = r_pv && ((is_reply && q_match && !r_hit)
                            || ((r_kind == KIND_PURGE) && q_aged));
    assign scan_end = (r_rd == r_count) && !r_pv;

    // result of the current item
    always_comb begin
        base_res            = '0;
        base_res.event_res  = r_kind;
        base_res.out_x      = r_key[X_W-1:0];
        base_res.out_y      = r_key[X_W+Y_W-1:X_W];
        base_res.out_zoom   = r_key[KEY_W-1:X_W+Y_W];
        base_res.last       = 1'b1;
        done_res            = '0;
        done_res.event_res  = EV_COMPLETE;
        done_res.last       = 1'b1;
    end

    always_comb begin
        res_count = 2'd0;
        case (r_kind)
            KIND_REQUEST: res_count = 2'd1;
            KIND_LOADED, KIND_EMPTY: begin
                if (r_hit) begin
                    res_count = (r_count == '0) ? 2'd2 : 2'd1;
                end
            end
            KIND_PURGE: res_count = (r_hit && r_count == '0) ? 2'd1 : 2'd0;
            KIND_QUERY: res_count = 2'd1;
            default:    res_count = 2'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_kind)
                    KIND_REQUEST: n_state = ST_DONE;
                    KIND_LOADED, KIND_EMPTY:
                        n_state = (r_id_ok && r_count != '0) ? ST_SCAN : ST_IDLE;
                    KIND_PURGE: n_state = (r_count != '0) ? ST_SCAN : ST_IDLE;
                    KIND_QUERY: n_state = (r_count != '0) ? ST_SCAN : ST_DONE;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_count <= q_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mem_re        = 1'b0;
        mem_raddr     = r_rd[AW-1:0];
        mem_we        = 1'b0;
        mem_waddr     = r_wr[AW-1:0];
        mem_wdata     = r_rdata;
        push          = '0;
        case (r_state)
            ST_EXEC: begin
                if (r_kind == KIND_REQUEST && r_count != FULL_COUNT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[AW-1:0];
                    mem_wdata = {r_key, r_now};
                end
            end
            ST_SCAN: begin
                mem_re = (r_rd < r_count);
                mem_we = r_pv && !drop;
            end
            ST_DONE: begin
                if (res_count <= q_free) begin
                    push.count = res_count;
                    push.r0    = base_res;
                    push.r1    = done_res;
                    case (r_kind)
                        KIND_REQUEST: push.r0.event_res = r_hit ? EV_FULL : EV_ISSUED;
                        KIND_LOADED, KIND_EMPTY: push.r0.last = (r_count != '0);
                        KIND_PURGE:   push.r0 = done_res;
                        KIND_QUERY: begin
                            push.r0.event_res  = EV_QUERY;
                            push.r0.is_pending = r_hit;
                        end
                        default: push.count = 2'd0;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_kind       = r_kind;
        n_key        = r_key;
        n_id_ok      = r_id_ok;
        n_own_source = r_own_source;
        n_own_layer  = r_own_layer;
        n_timeout    = r_timeout;
        n_now        = r_now;
        n_count      = r_count;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_pv         = r_pv;
        n_hit        = r_hit;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_SOURCE: n_own_source = i_cfg_data[SRC_W-1:0];
                CFG_OWN_LAYER:  n_own_layer  = i_cfg_data[LAY_W-1:0];
                CFG_TIMEOUT:    n_timeout    = i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind  = s_axis_tuser;
                    n_key   = s_axis_tdata[KEY_W-1:0];
                    n_id_ok = (s_axis_tdata[KEY_W+SRC_W-1:KEY_W] == r_own_source)
                           && (s_axis_tdata[KEY_W+SRC_W+LAY_W-1:KEY_W+SRC_W] == r_own_layer);
                end
            end
            ST_EXEC: begin
                n_rd  = '0;
                n_wr  = '0;
                n_pv  = 1'b0;
                n_hit = 1'b0;
                case (r_kind)
                    KIND_REQUEST: begin
                        n_hit = (r_count == FULL_COUNT);
                        if (r_count != FULL_COUNT) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    KIND_PURGE: n_hit = (r_count != '0);
                    KIND_TICK:  n_now = r_now + 1'b1;
                    default: ;
                endcase
            end
            ST_SCAN: begin
                n_pv = mem_re;
                if (mem_re) begin
                    n_rd = r_rd + 1'b1;
                end
                if (r_pv) begin
                    if (q_match) begin
                        n_hit = 1'b1;
                    end
                    if (!drop) begin
                        n_wr = r_wr + 1'b1;
                    end
                end
                if (scan_end) begin
                    n_count = r_wr;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_own_source <= '0;
            r_own_layer  <= '0;
            r_timeout    <= TIMEOUT_RESET;
            r_now        <= '0;
            r_count      <= '0;
            r_pv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_own_source <= n_own_source;
            r_own_layer  <= n_own_layer;
            r_timeout    <= n_timeout;
            r_now        <= n_now;
            r_count      <= n_count;
            r_pv         <= n_pv;
        end
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_id_ok <= n_id_ok;
        r_rd    <= n_rd;
        r_wr    <= n_wr;
        r_hit   <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_slot_mem[mem_raddr];
        end
    end

    ptrt_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_free        (q_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond table depth");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_wr <= r_rd))
        else $error("compaction write pointer ahead of read pointer");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_count))
        else $error("entry count changed while idle");

endmodule

>>> tb/pending_tile_request_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_tile_request_tracker_test
// Drives request, reply, tick, purge and query transactions into the tracker
// with random gaps and output stalls, predicts every event from a local copy
// of the request table and compares each output transaction field by field.
// ----------------------------------------------------------------------------
import ptrt_pkg::*;

class tracker_model;
    logic [SRC_W-1:0]   own_src;
    logic [LAY_W-1:0]   own_lay;
    logic [TMO_W-1:0]   timeout;
    logic [STAMP_W-1:0] now_ms;
    logic [KEY_W-1:0]   keys[$];
    logic [STAMP_W-1:0] stamps[$];
    t_result            events_due[$];
    int                 mismatches;

    function new();
        own_src    = '0;
        own_lay    = '0;
        timeout    = TIMEOUT_RESET;
        now_ms     = '0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OWN_SOURCE: own_src = data[SRC_W-1:0];
            CFG_OWN_LAYER:  own_lay = data[LAY_W-1:0];
            CFG_TIMEOUT:    timeout = data[TMO_W-1:0];
            default: ;
        endcase
    endfunction

    function int fill();
        return keys.size();
    endfunction

    function void entry_coords(int i, output logic [X_W-1:0] x,
                               output logic [Y_W-1:0] y, output logic [Z_W-1:0] z);
        x = keys[i][X_W-1:0];
        y = keys[i][X_W+:Y_W];
        z = keys[i][X_W+Y_W+:Z_W];
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
        foreach (keys[i])
            if (keys[i] == key)
                return i;
        return -1;
    endfunction

    function void push_event(logic [EV_W-1:0] ev, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                             logic [Z_W-1:0] z, logic pend, logic last);
        t_result r;
        r.event_res  = ev;
        r.out_x      = x;
        r.out_y      = y;
        r.out_zoom   = z;
        r.is_pending = pend;
        r.last       = last;
        events_due = {events_due, r};
    endfunction

    function void accept_item(logic [KIND_W-1:0] kind, logic [X_W-1:0] x,
                              logic [Y_W-1:0] y, logic [Z_W-1:0] z,
                              logic [SRC_W-1:0] src, logic [LAY_W-1:0] lay);
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] age;
        logic [EV_W-1:0]    ev;
        int                 idx;
        int                 i;
        key = {z, y, x};
        case (kind)
            KIND_REQUEST: begin
                if (keys.size() >= TABLE_DEPTH_DEF) begin
                    push_event(EV_FULL, x, y, z, 1'b0, 1'b1);
                end else begin
                    keys   = {keys, key};
                    stamps = {stamps, now_ms};
                    push_event(EV_ISSUED, x, y, z, 1'b0, 1'b1);
                end
            end
            KIND_LOADED, KIND_EMPTY: begin
                if (src != own_src || lay != own_lay)
                    return;
                idx = find_key(key);
                if (idx < 0)
                    return;
                keys.delete(idx);
                stamps.delete(idx);
                ev = (kind == KIND_LOADED) ? EV_LOADED : EV_EMPTY;
                if (keys.size() == 0) begin
                    push_event(ev, x, y, z, 1'b0, 1'b0);
                    push_event(EV_COMPLETE, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    push_event(ev, x, y, z, 1'b0, 1'b1);
                end
            end
            KIND_TICK: now_ms = now_ms + 1;
            KIND_PURGE: begin
                if (keys.size() == 0)
                    return;
                i = 0;
                while (i < keys.size()) begin
                    age = now_ms - stamps[i];
                    if (age > {16'd0, timeout}) begin
                        keys.delete(i);
                        stamps.delete(i);
                    end else begin
                        i++;
                    end
                end
                if (keys.size() == 0)
                    push_event(EV_COMPLETE, '0, '0, '0, 1'b0, 1'b1);
            end
            KIND_QUERY: push_event(EV_QUERY, x, y, z, find_key(key) >= 0, 1'b1);
            default: ;
        endcase
    endfunction

    function void check_event(t_result got);
        t_result want;
        if (events_due.size() == 0) begin
            $error("unexpected output transaction: event_res %0d", got.event_res);
            mismatches++;
            return;
        end
        want = events_due.pop_front();
        if (got.event_res != want.event_res) begin
            $error("event_res expected %0d got %0d", want.event_res, got.event_res);
            mismatches++;
        end
        if (got.out_x != want.out_x) begin
            $error("out_x expected %h got %h", want.out_x, got.out_x);
            mismatches++;
        end
        if (got.out_y != want.out_y) begin
            $error("out_y expected %h got %h", want.out_y, got.out_y);
            mismatches++;
        end
        if (got.out_zoom != want.out_zoom) begin
            $error("out_zoom expected %0d got %0d", want.out_zoom, got.out_zoom);
            mismatches++;
        end
        if (got.is_pending != want.is_pending) begin
            $error("is_pending expected %0d got %0d", want.is_pending, got.is_pending);
            mismatches++;
        end
        if (got.last != want.last) begin
            $error("last expected %0d got %0d", want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module pending_tile_request_tracker_test;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int PAD_W         = S_TDATA_W - (X_W + Y_W + Z_W + SRC_W + LAY_W);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;  // tile_x, tile_y, zoom, reply_source,
                                          // reply_layer, pad
    logic [KIND_W-1:0]     s_axis_tuser;  // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;  // out_x, out_y, out_zoom, is_pending, pad
    logic [EV_W-1:0]       m_axis_tuser;  // event_res
    logic                  m_axis_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tracker_model tracker = new();
    bit           steady;
    int           stall_left = 0;

    pending_tile_request_tracker i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.event_res  = m_axis_tuser;
            got.out_x      = m_axis_tdata[X_W-1:0];
            got.out_y      = m_axis_tdata[X_W+:Y_W];
            got.out_zoom   = m_axis_tdata[X_W+Y_W+:Z_W];
            got.is_pending = m_axis_tdata[X_W+Y_W+Z_W];
            got.last       = m_axis_tlast;
            tracker.check_event(got);
        end
    end

    task automatic send_item(logic [KIND_W-1:0] kind, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                             logic [Z_W-1:0] z, logic [SRC_W-1:0] src,
                             logic [LAY_W-1:0] lay);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{PAD_W{1'b0}}, lay, src, z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.accept_item(kind, x, y, z, src, lay);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.events_due.size() != 0) @(posedge i_clk);
    endtask

    // block must be idle before register writes
    task automatic write_regs(logic [SRC_W-1:0] src, logic [LAY_W-1:0] lay,
                              logic [TMO_W-1:0] tmo);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OWN_SOURCE;
        i_cfg_data <= CFG_DATA_W'(src);
        tracker.write_reg(CFG_OWN_SOURCE, CFG_DATA_W'(src));
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OWN_LAYER;
        i_cfg_data <= CFG_DATA_W'(lay);
        tracker.write_reg(CFG_OWN_LAYER, CFG_DATA_W'(lay));
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TIMEOUT;
        i_cfg_data <= tmo;
        tracker.write_reg(CFG_TIMEOUT, tmo);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic void random_coords(output logic [X_W-1:0] x, output logic [Y_W-1:0] y,
                                          output logic [Z_W-1:0] z);
        // narrow coordinates make duplicates and near misses likely
        if ($urandom_range(0, 9) < 3) begin
            x = X_W'($urandom_range(0, 3));
            y = Y_W'($urandom_range(0, 3));
            z = Z_W'($urandom_range(0, 1));
        end else begin
            x = X_W'($urandom);
            y = Y_W'($urandom);
            z = Z_W'($urandom);
        end
    endfunction

    task automatic random_step(int req_w, output int sent);
        logic [KIND_W-1:0] kind;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [Z_W-1:0]    z;
        logic [SRC_W-1:0]  src;
        logic [LAY_W-1:0]  lay;
        int                n;
        int                r;
        int                burst;
        sent  = 1;
        burst = 0;
        n     = tracker.fill();
        r     = $urandom_range(0, 99);
        random_coords(x, y, z);
        src   = SRC_W'($urandom);
        lay   = LAY_W'($urandom);
        kind  = KIND_TICK;
        if (r < req_w) begin
            kind = KIND_REQUEST;
            if (n > 0 && $urandom_range(0, 3) == 0)
                tracker.entry_coords($urandom_range(0, n - 1), x, y, z);
        end else if (r < req_w + 28) begin
            kind = $urandom_range(0, 1) ? KIND_LOADED : KIND_EMPTY;
            src  = tracker.own_src;
            lay  = tracker.own_lay;
            if (n > 0 && $urandom_range(0, 9) < 7)
                tracker.entry_coords($urandom_range(0, n - 1), x, y, z);
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1))
                    src = src ^ SRC_W'($urandom_range(1, 255));
                else
                    lay = lay ^ LAY_W'($urandom_range(1, 255));
            end
        end else if (r < req_w + 43) begin
            kind = KIND_TICK;
            if ($urandom_range(0, 9) == 0)
                burst = $urandom_range(5, 20);
        end else if (r < req_w + 49) begin
            kind = KIND_PURGE;
        end else if (r < req_w + 58) begin
            kind = KIND_QUERY;
            if (n > 0 && $urandom_range(0, 1))
                tracker.entry_coords($urandom_range(0, n - 1), x, y, z);
        end else if (r < req_w + 60) begin
            kind = $urandom_range(0, 1) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
            sent = 0;
        end
        send_item(kind, x, y, z, src, lay);
        repeat (burst)
            send_item(KIND_TICK, X_W'($urandom), Y_W'($urandom), Z_W'($urandom),
                      SRC_W'($urandom), LAY_W'($urandom));
        sent += burst;
    endtask

    initial begin
        int               items;
        int               sent;
        int               req_w;
        logic [TMO_W-1:0] tmo;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_REQUEST;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_OWN_SOURCE;
        i_cfg_data    <= '0;
        steady        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, source 0 and layer 0
        send_item(KIND_QUERY, '0, '0, '0, '0, '0);
        send_item(KIND_REQUEST, '1, '1, '1, '1, '1);
        send_item(KIND_REQUEST, '0, '0, '0, '0, '0);
        send_item(KIND_QUERY, '1, '1, '1, '0, '0);
        send_item(KIND_LOADED, '1, '1, '1, 8'h01, '0);
        send_item(KIND_LOADED, '1, '1, '1, '0, 8'h80);
        send_item(KIND_LOADED, 24'd1, '0, '0, '0, '0);
        send_item(KIND_LOADED, '1, '1, '1, '0, '0);
        send_item(KIND_EMPTY, '0, '0, '0, '0, '0);
        send_item(KIND_UNUSED_LO, '1, '1, '1, '1, '1);
        send_item(KIND_UNUSED_HI, '0, '0, '0, '0, '0);
        send_item(KIND_PURGE, '0, '0, '0, '0, '0);
        send_item(KIND_REQUEST, 24'h5A5A5A, 24'hA5A5A5, 5'd10, '0, '0);
        send_item(KIND_REQUEST, 24'h5A5A5A, 24'hA5A5A5, 5'd10, '0, '0);
        repeat (TABLE_DEPTH_DEF - 2)
            send_item(KIND_REQUEST, X_W'($urandom), Y_W'($urandom), Z_W'($urandom), '0, '0);
        send_item(KIND_REQUEST, 24'h123456, 24'h654321, 5'd21, '0, '0);
        send_item(KIND_PURGE, '0, '0, '0, '0, '0);

        // timeout of one: two ticks age every entry past it
        write_regs('0, '0, 16'd1);
        send_item(KIND_TICK, '0, '0, '0, '0, '0);
        send_item(KIND_TICK, '0, '0, '0, '0, '0);
        send_item(KIND_PURGE, '0, '0, '0, '0, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                write_regs('1, '1, '1);
            else if (ph == 1)
                write_regs('0, '0, 16'd1);
            else begin
                tmo = (ph == PHASES - 1) ? 16'hFFFF : TMO_W'($urandom_range(2, 40));
                write_regs(SRC_W'($urandom), LAY_W'($urandom), tmo);
            end
            steady = (ph == 3);
            req_w  = $urandom_range(25, 38);
            items  = 0;
            while (items < PHASE_ITEMS) begin
                random_step(req_w, sent);
                items += sent;
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.events_due.size() != 0) begin
            $error("%0d expected events never arrived", tracker.events_due.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
